FILE: rtl/first_fit_heap_allocator_top_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// Clocked implication checked outside reset.
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define FFHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and codes shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_STATS  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEM    = 2'd1,
    ST_BAD_PTR   = 2'd2,
    ST_DBL_FREE  = 2'd3
  } status_t;

  localparam logic [0:0] CFG_MIN_SPLIT  = 1'b0;
  localparam logic [0:0] CFG_HEAP_LIMIT = 1'b1;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_FIND_RD,    // find block by pointer
    S_FIND_CHK,
    S_FIT_RD,     // first-fit search
    S_FIT_CHK,
    S_GROW_RD,    // read last entry
    S_GROW_CHK,
    S_SPLIT,      // decide split
    S_SHIFT_RD,   // insert or drop shift, one entry per read and write
    S_SHIFT_WR,
    S_INS_WR,
    S_MARK,
    S_REL_NXT_RD,
    S_REL_NXT_CHK,
    S_REL_PRV_RD,
    S_REL_PRV_CHK,
    S_SUM_RD,
    S_SUM_ACC,
    S_DONE
  } state_t;

endpackage

FILE: rtl/first_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator with coalescing over an address-ordered block table.
// ----------------------------------------------------------------------------
// Channel | Ports                                         | Handshake
// in      | in_opcode, in_request_size, in_pointer_offset | start / busy
// out     | out_status ... out_block_count                | out_valid, one cycle
// cfg     | cfg_index, cfg_data                           | cfg_valid / cfg_ready
//
// Each request makes one or more walks over the N blocks held: a
// pointer search (twice for a moving resize), a first-fit search (twice after
// growth), an ordered shift of the tail on insert or remove and a final walk
// summing used and free bytes.
// All walks go through the single read port of the block table memory.
// Reset (rst_n low, synchronous) restores one free block covering 64 KB; no
// clearing pass is needed. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
  parameter int MAX_BLOCKS       = 256,
  parameter int HEAP_MAX_BYTES   = 67108864,
  parameter int HEADER_BYTES     = 20,
  parameter int GROW_CHUNK_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [26:0] in_request_size,
  input  logic [25:0] in_pointer_offset,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [25:0] out_result_offset,
  output logic [26:0] out_used_bytes,
  output logic [26:0] out_free_bytes,
  output logic [26:0] out_heap_bytes,
  output logic [8:0]  out_block_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [26:0] cfg_data
);
  import ffha_pkg::*;
  `include "first_fit_heap_allocator_top_macros.svh"

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = AW + 1;
  localparam int EW = 53; // start 26, payload 26, used 1
  localparam int CHUNK_SH = $clog2(GROW_CHUNK_BYTES);
  localparam logic [26:0] INIT_PAY = 27'(65536 - HEADER_BYTES);
  localparam logic [27:0] HDR = 28'(HEADER_BYTES);

  // Return points after a table shift.
  localparam logic [1:0] RET_MARK    = 2'd0;
  localparam logic [1:0] RET_REL_PRV = 2'd1;
  localparam logic [1:0] RET_SUM     = 2'd2;

  // Block table: {start, payload, used}. Entry 0 comes from reset registers
  // until first written.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata_m;
  logic          e0_dirty_r, e0_dirty_nxt;

  ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_m)
  );

  logic rd0_r;
  logic [EW-1:0] rdata;
  always_comb begin
    rdata = rdata_m;
    if (rd0_r && !e0_dirty_r) rdata = {26'd0, INIT_PAY[25:0], 1'b0};
  end
  logic [25:0] r_start, r_pay;
  logic        r_used;
  assign r_start = rdata[52:27];
  assign r_pay   = rdata[26:1];
  assign r_used  = rdata[0];

  state_t state_r, state_nxt;
  logic [12:0] min_split_r, min_split_nxt;
  logic [26:0] limit_r, limit_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [26:0] heap_top_r, heap_top_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [27:0] size_r, size_nxt;      // rounded request
  logic [26:0] req_r, req_nxt;        // raw request
  logic [25:0] ptr_r, ptr_nxt;
  logic [CW-1:0] idx_r, idx_nxt;      // walk index
  logic [CW-1:0] k_r, k_nxt;          // found block
  logic [CW-1:0] tgt_r, tgt_nxt;      // shift target
  logic          ins_r, ins_nxt;      // shift direction: 1 insert
  logic [EW-1:0] ins_e_r, ins_e_nxt;  // entry to write at insert slot
  logic [EW-1:0] cur_r, cur_nxt;      // held copy of entry k
  logic          grown_r, grown_nxt;
  logic          rsz_r, rsz_nxt;      // release old block after alloc
  logic [1:0]  ret_r, ret_nxt;        // return point after shift
  logic [1:0]  status_r, status_nxt;
  logic [25:0] res_r, res_nxt;
  logic [26:0] used_acc_r, used_acc_nxt, free_acc_r, free_acc_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  ost_r;
  logic [25:0] ooff_r;
  logic [26:0] oused_r, ofree_r;

  logic [27:0] chunk;
  logic [27:0] eff_limit;
  logic [27:0] grow_sum;
  always_comb begin
    chunk = ((size_r + HDR + 28'(GROW_CHUNK_BYTES - 1)) >> CHUNK_SH) << CHUNK_SH;
    eff_limit = (limit_r > 27'(HEAP_MAX_BYTES)) ? 28'(HEAP_MAX_BYTES) : {1'b0, limit_r};
    grow_sum = {1'b0, heap_top_r} + chunk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      min_split_r <= 13'd32;
      limit_r <= 27'(HEAP_MAX_BYTES);
      held_r <= CW'(1);
      heap_top_r <= 27'd65536;
      e0_dirty_r <= 1'b0;
      ov_r <= 1'b0;
      rd0_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      min_split_r <= min_split_nxt;
      limit_r <= limit_nxt;
      held_r <= held_nxt;
      heap_top_r <= heap_top_nxt;
      e0_dirty_r <= e0_dirty_nxt;
      ov_r <= ov_nxt;
      rd0_r <= (raddr == '0);
    end
    op_r <= op_nxt; size_r <= size_nxt; req_r <= req_nxt; ptr_r <= ptr_nxt;
    idx_r <= idx_nxt; k_r <= k_nxt; tgt_r <= tgt_nxt; ins_r <= ins_nxt;
    ins_e_r <= ins_e_nxt; cur_r <= cur_nxt; grown_r <= grown_nxt; rsz_r <= rsz_nxt;
    ret_r <= ret_nxt; status_r <= status_nxt; res_r <= res_nxt;
    used_acc_r <= used_acc_nxt; free_acc_r <= free_acc_nxt;
    if (ov_nxt) begin
      ost_r <= status_r; ooff_r <= res_r; oused_r <= used_acc_r; ofree_r <= free_acc_r;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_result_offset = ooff_r;
  assign out_used_bytes = oused_r;
  assign out_free_bytes = ofree_r;
  assign out_heap_bytes = heap_top_r;
  assign out_block_count = 9'(held_r);

  // Split threshold: rounded request plus header plus minimum split size.
  logic [27:0] cmp_split;
  assign cmp_split = size_r + HDR + {15'd0, min_split_r};

  always_comb begin
    state_nxt = state_r; min_split_nxt = min_split_r; limit_nxt = limit_r;
    held_nxt = held_r; heap_top_nxt = heap_top_r; e0_dirty_nxt = e0_dirty_r;
    op_nxt = op_r; size_nxt = size_r; req_nxt = req_r; ptr_nxt = ptr_r;
    idx_nxt = idx_r; k_nxt = k_r; tgt_nxt = tgt_r; ins_nxt = ins_r;
    ins_e_nxt = ins_e_r; cur_nxt = cur_r; grown_nxt = grown_r; rsz_nxt = rsz_r;
    ret_nxt = ret_r; status_nxt = status_r; res_nxt = res_r;
    used_acc_nxt = used_acc_r; free_acc_nxt = free_acc_r;
    ov_nxt = 1'b0;
    we = 1'b0; waddr = '0; wdata = '0; raddr = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == CFG_MIN_SPLIT) min_split_nxt = cfg_data[12:0];
          else limit_nxt = cfg_data;
        end
        if (start) begin
          op_nxt = in_opcode; req_nxt = in_request_size; ptr_nxt = in_pointer_offset;
          size_nxt = ({1'b0, in_request_size} + 28'd7) & ~28'd7;
          status_nxt = ST_OK; res_nxt = '0; grown_nxt = 1'b0; rsz_nxt = 1'b0;
          idx_nxt = '0;
          if (in_opcode == OP_STATS) state_nxt = S_SUM_RD;
          else if (in_opcode == OP_ALLOC ||
                   (in_opcode == OP_RESIZE && in_pointer_offset == '0)) begin
            state_nxt = (in_request_size == '0) ? S_SUM_RD : S_FIT_RD;
          end else if (in_pointer_offset == '0) state_nxt = S_SUM_RD; // null free
          else state_nxt = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        raddr = idx_r[AW-1:0];
        state_nxt = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if ({1'b0, r_start} + HDR[26:0] == {1'b0, ptr_r}) begin
          k_nxt = idx_r; cur_nxt = rdata;
          if (rsz_r) begin
            state_nxt = S_REL_NXT_RD; // release old after resize grant
          end else if (op_r == OP_FREE || req_r == '0) begin
            if (!r_used) begin
              status_nxt = ST_DBL_FREE;
              state_nxt = S_SUM_RD;
            end else state_nxt = S_REL_NXT_RD;
          end else if (!r_used) begin
            status_nxt = ST_BAD_PTR; state_nxt = S_SUM_RD;
          end else if ({1'b0, r_pay} >= req_r) begin
            res_nxt = ptr_r; state_nxt = S_SUM_RD;
          end else begin
            idx_nxt = '0; state_nxt = S_FIT_RD;
          end
        end else if (idx_r + CW'(1) >= held_r) begin
          if (!rsz_r) status_nxt = ST_BAD_PTR;
          state_nxt = S_SUM_RD;
        end else begin
          idx_nxt = idx_r + CW'(1); state_nxt = S_FIND_RD;
        end
      end
      S_FIT_RD: begin
        state_nxt = S_FIT_CHK;
      end
      S_FIT_CHK: begin
        if (!r_used && {2'b0, r_pay} >= size_r) begin
          k_nxt = idx_r; cur_nxt = rdata; state_nxt = S_SPLIT;
        end else if (idx_r + CW'(1) >= held_r) begin
          if (grown_r) begin
            status_nxt = ST_NO_MEM; state_nxt = S_SUM_RD;
          end else begin
            idx_nxt = held_r - CW'(1); state_nxt = S_GROW_RD;
          end
        end else begin
          idx_nxt = idx_r + CW'(1); state_nxt = S_FIT_RD;
        end
      end
      S_GROW_RD: state_nxt = S_GROW_CHK;
      S_GROW_CHK: begin
        if (grow_sum > eff_limit) begin
          status_nxt = ST_NO_MEM; state_nxt = S_SUM_RD;
        end else if (!r_used) begin
          we = 1'b1; waddr = idx_r[AW-1:0];
          wdata = {r_start, r_pay + chunk[25:0], 1'b0};
          if (idx_r == '0) e0_dirty_nxt = 1'b1;
          heap_top_nxt = grow_sum[26:0];
          grown_nxt = 1'b1; idx_nxt = '0; state_nxt = S_FIT_RD;
        end else if (held_r >= CW'(MAX_BLOCKS)) begin
          status_nxt = ST_NO_MEM; state_nxt = S_SUM_RD;
        end else begin
          we = 1'b1; waddr = held_r[AW-1:0];
          wdata = {heap_top_r[25:0], chunk[25:0] - HDR[25:0], 1'b0};
          held_nxt = held_r + CW'(1);
          heap_top_nxt = grow_sum[26:0];
          grown_nxt = 1'b1; idx_nxt = '0; state_nxt = S_FIT_RD;
        end
      end
      S_SPLIT: begin
        res_nxt = cur_r[52:27] + HDR[25:0];
        if ({2'b0, cur_r[26:1]} >= cmp_split && held_r < CW'(MAX_BLOCKS)) begin
          cur_nxt = {cur_r[52:27], size_r[25:0], 1'b0};
          ins_e_nxt = {cur_r[52:27] + HDR[25:0] + size_r[25:0],
                       cur_r[26:1] - size_r[25:0] - HDR[25:0], 1'b0};
          ins_nxt = 1'b1; tgt_nxt = k_r + CW'(1);
          idx_nxt = held_r; // move entry idx-1 to idx, down to tgt
          held_nxt = held_r + CW'(1);
          ret_nxt = RET_MARK;
          state_nxt = (held_r == k_r + CW'(1)) ? S_INS_WR : S_SHIFT_RD;
        end else state_nxt = S_MARK;
      end
      S_SHIFT_RD: begin
        raddr = ins_r ? AW'(idx_r - CW'(1)) : AW'(idx_r + CW'(1));
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        we = 1'b1; waddr = idx_r[AW-1:0]; wdata = rdata;
        if (idx_r == '0) e0_dirty_nxt = 1'b1;
        if (ins_r) begin
          if (idx_r - CW'(1) == tgt_r) state_nxt = S_INS_WR;
          else begin idx_nxt = idx_r - CW'(1); state_nxt = S_SHIFT_RD; end
        end else begin
          if (idx_r + CW'(1) >= held_r) state_nxt = S_INS_WR;
          else begin idx_nxt = idx_r + CW'(1); state_nxt = S_SHIFT_RD; end
        end
      end
      S_INS_WR: begin
        if (ins_r) begin
          we = 1'b1; waddr = tgt_r[AW-1:0]; wdata = ins_e_r;
        end
        case (ret_r)
          RET_MARK: state_nxt = S_MARK;
          RET_REL_PRV: state_nxt = S_REL_PRV_RD;
          default: state_nxt = S_SUM_RD;
        endcase
      end
      S_MARK: begin
        we = 1'b1; waddr = k_r[AW-1:0]; wdata = {cur_r[52:1], 1'b1};
        if (k_r == '0) e0_dirty_nxt = 1'b1;
        if (op_r == OP_RESIZE && ptr_r != '0) begin
          rsz_nxt = 1'b1; idx_nxt = '0; state_nxt = S_FIND_RD;
        end else state_nxt = S_SUM_RD;
      end
      S_REL_NXT_RD: begin
        raddr = AW'(k_r + CW'(1));
        state_nxt = S_REL_NXT_CHK;
      end
      S_REL_NXT_CHK: begin
        cur_nxt = {cur_r[52:1], 1'b0};
        if (k_r + CW'(1) < held_r && !r_used) begin
          cur_nxt = {cur_r[52:27], cur_r[26:1] + HDR[25:0] + r_pay, 1'b0};
          ins_nxt = 1'b0; idx_nxt = k_r + CW'(1);
          held_nxt = held_r - CW'(1);
          ret_nxt = RET_REL_PRV;
          state_nxt = (k_r + CW'(2) >= held_r) ? S_INS_WR : S_SHIFT_RD;
        end else state_nxt = S_REL_PRV_RD;
      end
      S_REL_PRV_RD: begin
        we = 1'b1; waddr = k_r[AW-1:0]; wdata = cur_r;
        if (k_r == '0) e0_dirty_nxt = 1'b1;
        raddr = AW'(k_r - CW'(1));
        state_nxt = (k_r == '0) ? S_SUM_RD : S_REL_PRV_CHK;
        idx_nxt = '0;
      end
      S_REL_PRV_CHK: begin
        if (!r_used) begin
          we = 1'b1; waddr = AW'(k_r - CW'(1));
          wdata = {r_start, r_pay + HDR[25:0] + cur_r[26:1], 1'b0};
          if (k_r == CW'(1)) e0_dirty_nxt = 1'b1;
          ins_nxt = 1'b0; idx_nxt = k_r; held_nxt = held_r - CW'(1);
          ret_nxt = RET_SUM;
          state_nxt = (k_r + CW'(1) >= held_r) ? S_INS_WR : S_SHIFT_RD;
        end else begin
          idx_nxt = '0; state_nxt = S_SUM_RD;
        end
      end
      S_SUM_RD: begin
        if (idx_r == '0) begin used_acc_nxt = '0; free_acc_nxt = '0; end
        state_nxt = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        if (r_used) used_acc_nxt = used_acc_r + {1'b0, r_pay};
        else free_acc_nxt = free_acc_r + {1'b0, r_pay};
        if (idx_r + CW'(1) >= held_r) state_nxt = S_DONE;
        else begin idx_nxt = idx_r + CW'(1); state_nxt = S_SUM_RD; end
      end
      S_DONE: begin
        ov_nxt = 1'b1; idx_nxt = '0; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // Start every summing walk from entry 0.
    if (state_nxt == S_SUM_RD && state_r != S_SUM_ACC) idx_nxt = '0;
  end

  `FFHA_ASSERT_NXT(a_strobe_one, out_valid, !out_valid, "result strobe longer than one cycle")
  `FFHA_ASSERT_IMP(a_held_range, 1'b1, held_r != '0 && held_r <= CW'(MAX_BLOCKS), "block count out of range")
  `FFHA_ASSERT_IMP(a_idle_no_write, state_r == S_IDLE, !we, "table written while idle")
  `FFHA_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")

endmodule

FILE: rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives allocate, free, resize and stats requests into the first-fit heap
// allocator, predicts every result from a local copy of the block table and
// compares each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import ffha_pkg::*;

  localparam int NBLK = 256;
  localparam int HDR = 20;
  localparam int CHUNK = 65536;
  localparam int HMAX = 67108864;

  typedef struct packed {
    status_t     status;
    logic [25:0] offset;
    logic [26:0] used;
    logic [26:0] free;
    logic [26:0] heap;
    logic [8:0]  count;
  } heap_word_t;

  class heap_scoreboard;
    heap_word_t pending[$];
    int errors;
    int checked;

    function void note(heap_word_t w);
      pending.push_back(w);
    endfunction

    function void check(heap_word_t got);
      heap_word_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word got=%p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status exp=%0d act=%0d", $time, want.status, got.status);
        errors++;
      end
      if (got.offset !== want.offset) begin
        $display("%0t: offset exp=%0d act=%0d", $time, want.offset, got.offset);
        errors++;
      end
      if (got.used !== want.used) begin
        $display("%0t: used exp=%0d act=%0d", $time, want.used, got.used);
        errors++;
      end
      if (got.free !== want.free) begin
        $display("%0t: free exp=%0d act=%0d", $time, want.free, got.free);
        errors++;
      end
      if (got.heap !== want.heap) begin
        $display("%0t: heap exp=%0d act=%0d", $time, want.heap, got.heap);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count exp=%0d act=%0d", $time, want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0, start = 0, cfg_valid = 0;
  logic busy, out_valid, cfg_ready;
  logic [1:0] in_opcode = 0;
  logic [26:0] in_request_size = 0;
  logic [25:0] in_pointer_offset = 0;
  logic [1:0] out_status;
  logic [25:0] out_result_offset;
  logic [26:0] out_used_bytes, out_free_bytes, out_heap_bytes;
  logic [8:0] out_block_count;
  logic [0:0] cfg_index = 0;
  logic [26:0] cfg_data = 0;

  first_fit_heap_allocator_top dut (.*);

  initial forever #10 clk = ~clk;

  // Local copy of the block table.
  longint bstart[NBLK], bpay[NBLK];
  bit     bused[NBLK];
  int     nheld;
  longint heap_top, split_min, heap_cap;
  longint live[$];  // granted payload offsets
  heap_scoreboard sb;

  function automatic void tbl_drop(int i);
    for (int j = i; j < nheld - 1; j++) begin
      bstart[j] = bstart[j+1]; bpay[j] = bpay[j+1]; bused[j] = bused[j+1];
    end
    nheld--;
  endfunction

  function automatic void tbl_add(int i, longint s, longint p);
    for (int j = nheld; j > i; j--) begin
      bstart[j] = bstart[j-1]; bpay[j] = bpay[j-1]; bused[j] = bused[j-1];
    end
    bstart[i] = s; bpay[i] = p; bused[i] = 0;
    nheld++;
  endfunction

  function automatic int find_ptr(longint p);
    for (int i = 0; i < nheld; i++) if (bstart[i] + HDR == p) return i;
    return -1;
  endfunction

  function automatic int fit(longint sz);
    for (int i = 0; i < nheld; i++) if (!bused[i] && bpay[i] >= sz) return i;
    return -1;
  endfunction

  function automatic bit grow(longint sz);
    longint ch, lim;
    ch = ((sz + HDR + CHUNK - 1) / CHUNK) * CHUNK;
    lim = heap_cap > HMAX ? HMAX : heap_cap;
    if (heap_top + ch > lim) return 0;
    if (!bused[nheld-1]) bpay[nheld-1] += ch;
    else begin
      if (nheld >= NBLK) return 0;
      tbl_add(nheld, heap_top, ch - HDR);
    end
    heap_top += ch;
    return 1;
  endfunction

  function automatic longint grant(longint req);
    longint sz;
    int f;
    sz = (req + 7) & ~64'd7;
    f = fit(sz);
    if (f < 0) begin
      if (!grow(sz)) return 0;
      f = fit(sz);
      if (f < 0) return 0;
    end
    if (bpay[f] >= sz + HDR + split_min && nheld < NBLK) begin
      tbl_add(f + 1, bstart[f] + HDR + sz, bpay[f] - sz - HDR);
      bpay[f] = sz;
    end
    bused[f] = 1;
    return bstart[f] + HDR;
  endfunction

  function automatic void coalesce(int i);
    bused[i] = 0;
    if (i + 1 < nheld && !bused[i+1]) begin
      bpay[i] += HDR + bpay[i+1];
      tbl_drop(i + 1);
    end
    if (i > 0 && !bused[i-1]) begin
      bpay[i-1] += HDR + bpay[i];
      tbl_drop(i);
    end
  endfunction

  function automatic status_t release_ptr(longint p);
    int k;
    if (p == 0) return ST_OK;
    k = find_ptr(p);
    if (k < 0) return ST_BAD_PTR;
    if (!bused[k]) return ST_DBL_FREE;
    coalesce(k);
    return ST_OK;
  endfunction

  function automatic void forget(longint p);
    foreach (live[i]) if (live[i] == p) begin live.delete(i); break; end
  endfunction

  function automatic heap_word_t predict_heap(op_t op, longint sz, longint p);
    heap_word_t w;
    status_t st;
    longint off, u, fr;
    int k;
    st = ST_OK; off = 0;
    if (op == OP_ALLOC || (op == OP_RESIZE && p == 0)) begin
      if (sz != 0) begin
        off = grant(sz);
        if (off == 0) st = ST_NO_MEM; else live.push_back(off);
      end
    end else if (op == OP_FREE) begin
      st = release_ptr(p);
      if (st == ST_OK) forget(p);
    end else if (op == OP_RESIZE) begin
      if (sz == 0) begin
        st = release_ptr(p);
        if (st == ST_OK) forget(p);
      end else begin
        k = find_ptr(p);
        if (k < 0 || !bused[k]) st = ST_BAD_PTR;
        else if (bpay[k] >= sz) off = p;
        else begin
          off = grant(sz);
          if (off == 0) st = ST_NO_MEM;
          else begin
            k = find_ptr(p);
            if (k >= 0) coalesce(k);
            forget(p);
            live.push_back(off);
          end
        end
      end
    end
    u = 0; fr = 0;
    for (int i = 0; i < nheld; i++) if (bused[i]) u += bpay[i]; else fr += bpay[i];
    w.status = st; w.offset = off[25:0]; w.used = u[26:0]; w.free = fr[26:0];
    w.heap = heap_top[26:0]; w.count = nheld[8:0];
    return w;
  endfunction

  int burst_left = 0;

  task automatic send_req(op_t op, logic [26:0] sz, logic [25:0] p);
    // Gap between bursts.
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
    burst_left--;
    in_opcode <= op; in_request_size <= sz; in_pointer_offset <= p;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(predict_heap(op, sz, p));
    start <= 0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [26:0] v);
    cfg_index <= idx; cfg_data <= v; cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == CFG_MIN_SPLIT) split_min = v & 27'h1FFF; else heap_cap = v;
    @(posedge clk);
  endtask

  function automatic logic [25:0] pick_ptr();
    int r;
    r = $urandom_range(0, 9);
    if (live.size() != 0 && r < 7) return 26'(live[$urandom_range(0, live.size() - 1)]);
    if (r == 7) return '0;
    if (r == 8) return 26'($urandom);
    return (live.size() != 0) ? 26'(live[0] + 8) : 26'd20;
  endfunction

  function automatic logic [26:0] pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return 27'($urandom);
    if (r < 4) return 27'($urandom_range(1000, 70000));
    return 27'($urandom_range(1, 300));
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_req(OP_ALLOC, pick_size(), 26'($urandom));
      else if (r < 75) send_req(OP_FREE, 27'($urandom), pick_ptr());
      else if (r < 93) send_req(OP_RESIZE, pick_size(), pick_ptr());
      else send_req(OP_STATS, 27'($urandom), 26'($urandom));
    end
  endtask

  // Results cannot be held off: sample every strobe.
  always @(posedge clk)
    if (rst_n && out_valid)
      sb.check({status_t'(out_status), out_result_offset, out_used_bytes,
                out_free_bytes, out_heap_bytes, out_block_count});

  initial begin
    longint p;
    sb = new();
    bstart[0] = 0; bpay[0] = CHUNK - HDR; bused[0] = 0; nheld = 1;
    heap_top = CHUNK; split_min = 32; heap_cap = HMAX;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: special cases and field extremes.
    send_req(OP_STATS, 27'h7FFFFFF, 26'h3FFFFFF);
    send_req(OP_ALLOC, 0, 0);
    send_req(OP_FREE, 0, 0);
    send_req(OP_FREE, 0, 26'h3FFFFFF);
    send_req(OP_ALLOC, 1, 0);
    p = live[0];
    send_req(OP_RESIZE, 4, 26'(p));
    send_req(OP_RESIZE, 200, 26'(p));
    send_req(OP_FREE, 0, 26'(p));
    send_req(OP_FREE, 0, 26'(live[0]));
    send_req(OP_FREE, 0, 26'(live[0]));
    send_req(OP_RESIZE, 16, 26'd20);
    send_req(OP_RESIZE, 64, 0);
    send_req(OP_RESIZE, 0, 26'(live[0]));
    send_req(OP_ALLOC, 100000, 0);
    send_req(OP_ALLOC, 27'h7FFFFFF, 0);
    send_req(OP_ALLOC, 67108864, 0);
    send_req(OP_ALLOC, 65516, 0);
    drain();
    write_reg(CFG_HEAP_LIMIT, 27'd65536);
    write_reg(CFG_MIN_SPLIT, 13'd0);
    send_req(OP_ALLOC, 70000, 0);
    random_phase(200);
    drain();
    write_reg(CFG_MIN_SPLIT, 13'h1FFF);
    write_reg(CFG_HEAP_LIMIT, 27'h7FFFFFF);
    random_phase(200);
    drain();
    write_reg(CFG_MIN_SPLIT, 13'd4096);
    write_reg(CFG_HEAP_LIMIT, 27'd1048576);
    random_phase(250);
    drain();
    write_reg(CFG_MIN_SPLIT, 13'd8);
    write_reg(CFG_HEAP_LIMIT, 27'd67108864);
    random_phase(250);
    drain();
    $display("Covered %0d result words over four register settings, %0d blocks at end.",
             sb.checked, nheld);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #1000000000;
    $display("Verification failed");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator_top.sv
bench/tb_top.sv
